FILE: rtl/core/gls_pkg.sv
// shared widths, constants and the gap close command for the gap scorer
`default_nettype none
package gls_pkg;

   localparam int TIME_W        = 48;
   localparam int VAL_W         = 32;
   localparam int SUM_W         = 63;
   localparam int COUNT_W       = 32;
   localparam int GAP_DEPTH_DEF = 64;
   localparam int REQ_TDATA_W   = 80;
   localparam int RSP_TDATA_W   = 336;
   localparam int PROD_W        = 81;
   localparam int QUO_W         = 41;

   localparam logic [SUM_W-1:0] MAX63   = {SUM_W{1'b1}};
   localparam logic [QUO_W-1:0] QUO_CAP = {1'b1, {(QUO_W-1){1'b0}}};

   typedef struct packed {
      logic [TIME_W-1:0]  left_time;
      logic [VAL_W-1:0]   left_value;
      logic [TIME_W-1:0]  right_time;
      logic [VAL_W-1:0]   right_value;
      logic               overflowed;
      logic [COUNT_W-1:0] missing;
   } close_cmd_type;

endpackage
`default_nettype wire

FILE: rtl/core/gap_linear_interpolation_scorer_top.sv
// Gap scorer by linear interpolation: input channel, result channel.
// Input words (req_) carry a timestamp and a Q16.16 value; req_tuser marks a
// corrupted sample. A corrupted word is buffered, a good word with no open
// gap moves the left point. A good word that closes a gap is accepted and
// queued for the back end, which reads the buffered samples one at a time
// and gives one result word per sample, in arrival order, rsp_tlast on the
// last one of the gap. Each result passes through a 24-bit split multiply
// and an 81-step restoring divider.
// Corrupted words are held off while a gap is still being scored, since they
// reuse the sample buffer; good words keep flowing until the close queue
// (two deep) is full.
// A stalled receiver holds the result register; the back end waits with the
// next result ready. Synchronous reset clears left point, fill level, totals
// and all valid flags; no buffer clearing pass is needed.
`default_nettype none
module gap_linear_interpolation_scorer_top #(
   parameter int GAP_DEPTH = gls_pkg::GAP_DEPTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   // sample_time, sample_value
   input  wire logic [gls_pkg::REQ_TDATA_W-1:0] req_tdata,
   // corrupted
   input  wire logic                            req_tuser,
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // gap_time, predicted, abs_error, sq_error, sum_abs, sum_sq, corrupt_count
   output      logic [gls_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output      logic                            rsp_tlast,
   // dropped
   output      logic                            rsp_tuser
);

   localparam int CW = $clog2(GAP_DEPTH + 1);
   localparam int AW = (GAP_DEPTH > 1) ? $clog2(GAP_DEPTH) : 1;

   gls_pkg::close_cmd_type push_cmd, head_cmd;
   logic [CW-1:0]          push_count, head_count;
   logic                   push, pop, full, empty, busy;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic [gls_pkg::TIME_W-1:0] rd_time;
   logic [gls_pkg::VAL_W-1:0]  rd_value;

   gls_front #(.GAP_DEPTH(GAP_DEPTH), .CW(CW), .AW(AW)) u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .push, .push_cmd, .push_count,
      .fifo_full (full),
      .back_busy (busy || !empty),
      .rd_en, .rd_addr, .rd_time, .rd_value
   );

   gls_fifo #(.CW(CW)) u_fifo (
      .clock, .reset, .push, .push_cmd, .push_count,
      .pop, .full, .empty, .head_cmd, .head_count
   );

   gls_back #(.GAP_DEPTH(GAP_DEPTH), .CW(CW), .AW(AW)) u_back (
      .clock, .reset,
      .q_valid (!empty), .q_cmd (head_cmd), .q_count (head_count), .q_pop (pop),
      .busy, .rd_en, .rd_addr, .rd_time, .rd_value,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast, .rsp_tuser
   );

endmodule
`default_nettype wire

FILE: rtl/core/gls_fifo.sv
// two-entry queue of gap close commands between front and back
`default_nettype none
module gls_fifo #(
   parameter int CW = 7
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire gls_pkg::close_cmd_type push_cmd,
   input  wire logic [CW-1:0]          push_count,
   input  wire logic                   pop,
   output      logic                   full,
   output      logic                   empty,
   output      gls_pkg::close_cmd_type head_cmd,
   output      logic [CW-1:0]          head_count
);

   gls_pkg::close_cmd_type cmd_ff [2];
   logic [CW-1:0]          cnt_ff [2];
   logic                   wr_ptr_ff, rd_ptr_ff;
   logic [1:0]             level_ff;

   assign full       = (level_ff == 2'd2);
   assign empty      = (level_ff == 2'd0);
   assign head_cmd   = cmd_ff[rd_ptr_ff];
   assign head_count = cnt_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         cmd_ff[wr_ptr_ff] <= push_cmd;
         cnt_ff[wr_ptr_ff] <= push_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         if (push && !pop) level_ff <= level_ff + 2'd1;
         else if (pop && !push) level_ff <= level_ff - 2'd1;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/gls_front.sv
// front end: takes sample words, buffers corrupted samples, issues gap closes
`default_nettype none
module gls_front #(
   parameter int GAP_DEPTH = gls_pkg::GAP_DEPTH_DEF,
   parameter int CW        = $clog2(GAP_DEPTH + 1),
   parameter int AW        = (GAP_DEPTH > 1) ? $clog2(GAP_DEPTH) : 1
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   input  wire logic [gls_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  wire logic                              req_tuser,
   output      logic                              push,
   output      gls_pkg::close_cmd_type            push_cmd,
   output      logic [CW-1:0]                     push_count,
   input  wire logic                              fifo_full,
   input  wire logic                              back_busy,
   input  wire logic                              rd_en,
   input  wire logic [AW-1:0]                     rd_addr,
   output      logic [gls_pkg::TIME_W-1:0]        rd_time,
   output      logic [gls_pkg::VAL_W-1:0]         rd_value
);

   logic [gls_pkg::TIME_W-1:0]  time_mem  [GAP_DEPTH];
   logic [gls_pkg::VAL_W-1:0]   value_mem [GAP_DEPTH];
   logic [gls_pkg::TIME_W-1:0]  left_time_ff, rd_time_ff;
   logic [gls_pkg::VAL_W-1:0]   left_value_ff, rd_value_ff;
   logic [CW-1:0]               count_ff;
   logic                        ovf_ff;
   logic [gls_pkg::COUNT_W-1:0] missing_ff;
   logic [gls_pkg::TIME_W-1:0]  in_time;
   logic [gls_pkg::VAL_W-1:0]   in_value;
   logic                        accept, wr_in, full_buf;

   assign in_time  = req_tdata[gls_pkg::TIME_W-1:0];
   assign in_value = req_tdata[gls_pkg::TIME_W +: gls_pkg::VAL_W];

   // corrupted words wait while a gap is still being scored out of the buffer
   assign req_tready = !fifo_full && (!req_tuser || !back_busy);
   assign accept     = req_tvalid && req_tready;
   assign full_buf   = (count_ff == CW'(GAP_DEPTH));
   assign wr_in      = accept && req_tuser && !full_buf;
   assign push       = accept && !req_tuser && (count_ff != '0);
   assign push_count = count_ff;

   always_comb begin
      push_cmd.left_time   = left_time_ff;
      push_cmd.left_value  = left_value_ff;
      push_cmd.right_time  = in_time;
      push_cmd.right_value = in_value;
      push_cmd.overflowed  = ovf_ff;
      push_cmd.missing     = missing_ff;
   end

   assign rd_time  = rd_time_ff;
   assign rd_value = rd_value_ff;

   always_ff @(posedge clock) begin
      if (wr_in) begin
         time_mem[count_ff[AW-1:0]]  <= in_time;
         value_mem[count_ff[AW-1:0]] <= in_value;
      end
      if (rd_en) begin
         rd_time_ff  <= time_mem[rd_addr];
         rd_value_ff <= value_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_time_ff  <= '0;
         left_value_ff <= '0;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         missing_ff    <= '0;
      end else if (accept) begin
         if (req_tuser) begin
            if (missing_ff != {gls_pkg::COUNT_W{1'b1}}) missing_ff <= missing_ff + 1'b1;
            if (full_buf) ovf_ff <= 1'b1;
            else count_ff <= count_ff + 1'b1;
         end else begin
            count_ff      <= '0;
            ovf_ff        <= 1'b0;
            left_time_ff  <= in_time;
            left_value_ff <= in_value;
         end
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/gls_back.sv
// back end: interpolates each buffered sample of a closed gap and scores it
`default_nettype none
module gls_back #(
   parameter int GAP_DEPTH = gls_pkg::GAP_DEPTH_DEF,
   parameter int CW        = $clog2(GAP_DEPTH + 1),
   parameter int AW        = (GAP_DEPTH > 1) ? $clog2(GAP_DEPTH) : 1
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              q_valid,
   input  wire gls_pkg::close_cmd_type            q_cmd,
   input  wire logic [CW-1:0]                     q_count,
   output      logic                              q_pop,
   output      logic                              busy,
   output      logic                              rd_en,
   output      logic [AW-1:0]                     rd_addr,
   input  wire logic [gls_pkg::TIME_W-1:0]        rd_time,
   input  wire logic [gls_pkg::VAL_W-1:0]         rd_value,
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   output      logic [gls_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output      logic                              rsp_tlast,
   output      logic                              rsp_tuser
);

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_DIFF, S_MLO, S_MHI, S_PADD, S_DIV,
      S_PRED, S_AE, S_SQ, S_ACC, S_OUT
   } state_type;

   localparam int TW = gls_pkg::TIME_W;
   localparam int VW = gls_pkg::VAL_W;
   localparam int SW = gls_pkg::SUM_W;
   localparam int PW = gls_pkg::PROD_W;
   localparam int QW = gls_pkg::QUO_W;

   function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
      logic [SW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SW] ? gls_pkg::MAX63 : s[SW-1:0];
   endfunction

   state_type              state_ff;
   logic [CW-1:0]          k_ff, count_ff;
   logic [TW-1:0]          lt_ff, gt_ff, dx_mag_ff, t_mag_ff;
   logic [VW-1:0]          lv_ff, pv_ff, pred_ff, ae_ff;
   logic                   ovf_ff, dx_neg_ff, dy_neg_ff, t_neg_ff;
   logic                   dx_zero_ff, dy_zero_ff, t_zero_ff;
   logic [VW:0]            dy_mag_ff;
   logic [gls_pkg::COUNT_W-1:0] missing_ff;
   logic [56:0]            plo_ff, phi_ff;
   logic [PW-1:0]          num_ff;
   logic [TW-1:0]          rem_ff;
   logic [QW-1:0]          q_ff;
   logic                   big_ff;
   logic [6:0]             dcnt_ff;
   logic [SW-1:0]          se_ff, abs_total_ff, sq_total_ff;
   logic                   rsp_tvalid_ff, rsp_tlast_ff, rsp_tuser_ff;
   logic [TW-1:0]          o_time_ff;
   logic [VW-1:0]          o_pred_ff, o_ae_ff;
   logic [SW-1:0]          o_se_ff, o_sabs_ff, o_ssq_ff;
   logic [gls_pkg::COUNT_W-1:0] o_cnt_ff;

   logic [TW:0]   dx_in, t_in;
   logic [VW:0]   dy_in, ae_diff_in;
   logic [TW:0]   rsh_in;
   logic          ge_in, neg_in, last_in;
   logic [QW-1:0] qc_in;
   logic [42:0]   sum_in;
   logic [VW-1:0] sat_in;
   logic [63:0]   se_full_in;

   assign dx_in  = {1'b0, q_cmd.right_time} - {1'b0, q_cmd.left_time};
   assign dy_in  = {q_cmd.right_value[VW-1], q_cmd.right_value}
                 - {q_cmd.left_value[VW-1], q_cmd.left_value};
   assign t_in   = {1'b0, rd_time} - {1'b0, lt_ff};
   assign rsh_in = {rem_ff, num_ff[PW-1]};
   assign ge_in  = (rsh_in >= {1'b0, dx_mag_ff});
   assign neg_in = dy_neg_ff ^ t_neg_ff ^ dx_neg_ff;
   assign qc_in  = (big_ff || (q_ff > gls_pkg::QUO_CAP)) ? gls_pkg::QUO_CAP : q_ff;
   assign sum_in = neg_in ? ({{11{lv_ff[VW-1]}}, lv_ff} - {2'b0, qc_in})
                          : ({{11{lv_ff[VW-1]}}, lv_ff} + {2'b0, qc_in});
   assign ae_diff_in = {pred_ff[VW-1], pred_ff} - {pv_ff[VW-1], pv_ff};
   assign se_full_in = 64'(ae_ff) * 64'(ae_ff);
   assign last_in    = ((k_ff + 1'b1) == count_ff);

   // signed 32-bit saturation of the interpolated sum
   always_comb begin
      if (sum_in[42] && !(&sum_in[41:31])) sat_in = {1'b1, {(VW-1){1'b0}}};
      else if (!sum_in[42] && (|sum_in[41:31])) sat_in = {1'b0, {(VW-1){1'b1}}};
      else sat_in = sum_in[VW-1:0];
   end

   assign q_pop   = (state_ff == S_IDLE) && q_valid;
   assign busy    = (state_ff != S_IDLE);
   assign rd_en   = (state_ff == S_READ);
   assign rd_addr = k_ff[AW-1:0];

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tdata  = {3'b0, o_cnt_ff, o_ssq_ff, o_sabs_ff, o_se_ff, o_ae_ff,
                        o_pred_ff, o_time_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         k_ff          <= '0;
         abs_total_ff  <= '0;
         sq_total_ff   <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready && state_ff != S_OUT) rsp_tvalid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  lt_ff      <= q_cmd.left_time;
                  lv_ff      <= q_cmd.left_value;
                  ovf_ff     <= q_cmd.overflowed;
                  missing_ff <= q_cmd.missing;
                  count_ff   <= q_count;
                  dx_neg_ff  <= dx_in[TW];
                  dx_mag_ff  <= dx_in[TW] ? TW'(~dx_in + 1'b1) : dx_in[TW-1:0];
                  dx_zero_ff <= (dx_in == '0);
                  dy_neg_ff  <= dy_in[VW];
                  dy_mag_ff  <= dy_in[VW] ? (~dy_in + 1'b1) : dy_in;
                  dy_zero_ff <= (dy_in == '0);
                  k_ff       <= '0;
                  state_ff   <= S_READ;
               end
            end
            S_READ: state_ff <= S_DIFF;
            S_DIFF: begin
               gt_ff     <= rd_time;
               pv_ff     <= rd_value;
               t_neg_ff  <= t_in[TW];
               t_mag_ff  <= t_in[TW] ? TW'(~t_in + 1'b1) : t_in[TW-1:0];
               t_zero_ff <= (t_in == '0);
               state_ff  <= S_MLO;
            end
            S_MLO: begin
               plo_ff   <= 57'(dy_mag_ff) * 57'(t_mag_ff[23:0]);
               state_ff <= S_MHI;
            end
            S_MHI: begin
               phi_ff   <= 57'(dy_mag_ff) * 57'(t_mag_ff[47:24]);
               state_ff <= S_PADD;
            end
            S_PADD: begin
               num_ff   <= PW'(plo_ff) + (PW'(phi_ff) << 24);
               rem_ff   <= '0;
               q_ff     <= '0;
               big_ff   <= 1'b0;
               dcnt_ff  <= 7'(PW - 1);
               state_ff <= S_DIV;
            end
            // restoring division, one quotient bit a cycle from bit 80 down
            S_DIV: begin
               rem_ff <= ge_in ? TW'(rsh_in - {1'b0, dx_mag_ff}) : rsh_in[TW-1:0];
               num_ff <= num_ff << 1;
               if (dcnt_ff >= 7'(QW)) big_ff <= big_ff | ge_in;
               else q_ff <= {q_ff[QW-2:0], ge_in};
               if (dcnt_ff == 7'd0) state_ff <= S_PRED;
               else dcnt_ff <= dcnt_ff - 7'd1;
            end
            S_PRED: begin
               pred_ff  <= (dx_zero_ff || t_zero_ff || dy_zero_ff) ? lv_ff : sat_in;
               state_ff <= S_AE;
            end
            S_AE: begin
               ae_ff    <= ae_diff_in[VW] ? VW'(~ae_diff_in + 1'b1) : ae_diff_in[VW-1:0];
               state_ff <= S_SQ;
            end
            S_SQ: begin
               se_ff    <= se_full_in[63] ? gls_pkg::MAX63 : se_full_in[SW-1:0];
               state_ff <= S_ACC;
            end
            S_ACC: begin
               abs_total_ff <= sat_add(abs_total_ff, SW'(ae_ff));
               sq_total_ff  <= sat_add(sq_total_ff, se_ff);
               state_ff     <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tlast_ff  <= last_in;
                  rsp_tuser_ff  <= ovf_ff;
                  o_time_ff     <= gt_ff;
                  o_pred_ff     <= pred_ff;
                  o_ae_ff       <= ae_ff;
                  o_se_ff       <= se_ff;
                  o_sabs_ff     <= abs_total_ff;
                  o_ssq_ff      <= sq_total_ff;
                  o_cnt_ff      <= missing_ff;
                  k_ff          <= k_ff + 1'b1;
                  state_ff      <= last_in ? S_IDLE : S_READ;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_abs_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> abs_total_ff >= $past(abs_total_ff))
      else $error("abs error total went down");
   a_sq_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> sq_total_ff >= $past(sq_total_ff))
      else $error("squared error total went down");
   a_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> k_ff < count_ff)
      else $error("gap entry index past fill level");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_tvalid_ff && !rsp_tready) |=> state_ff == S_OUT)
      else $error("result word overwritten before taken");
`endif

endmodule
`default_nettype wire

FILE: dv/tb_gap_linear_interpolation_scorer_top.sv
// testbench for the gap scorer: directed table, random gaps, self-checking predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_gap_linear_interpolation_scorer_top;

   localparam int DEPTH     = gls_pkg::GAP_DEPTH_DEF;
   localparam int TW        = gls_pkg::TIME_W;
   localparam int VW        = gls_pkg::VAL_W;
   localparam int SW        = gls_pkg::SUM_W;
   localparam int NW        = gls_pkg::COUNT_W;
   localparam int IDLE_MAX  = 20000;
   localparam int HOLD_LEN  = 1500;
   localparam int N_ITEMS   = 350;
   localparam int N_DIR     = 16;
   localparam logic [63:0] SQ_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef struct {
      logic [TW-1:0] stamp;
      logic [VW-1:0] value;
      logic          corrupt;
      logic          has_pred;   // typed-in prediction of first gap sample
      logic [VW-1:0] pred;
   } sample_row_type;

   typedef struct packed {
      logic [TW-1:0] gap_time;
      logic [VW-1:0] predicted;
      logic [VW-1:0] abs_error;
      logic [SW-1:0] sq_error;
      logic [SW-1:0] sum_abs;
      logic [SW-1:0] sum_sq;
      logic [NW-1:0] corrupt_count;
      logic          last;
      logic          dropped;
   } score_type;

   logic                               clock;
   logic                               reset;
   logic                               req_tvalid;
   logic                               req_tready;
   logic [gls_pkg::REQ_TDATA_W-1:0]    req_tdata;
   logic                               req_tuser;
   logic                               rsp_tvalid;
   logic                               rsp_tready;
   logic [gls_pkg::RSP_TDATA_W-1:0]    rsp_tdata;
   logic                               rsp_tlast;
   logic                               rsp_tuser;

   gap_linear_interpolation_scorer_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // predictor state
   logic [TW-1:0] left_t;
   logic [VW-1:0] left_v;
   logic [TW-1:0] gap_t[DEPTH];
   logic [VW-1:0] gap_v[DEPTH];
   int            gap_fill;
   logic          gap_overflow;
   logic [SW-1:0] abs_sum;
   logic [SW-1:0] sq_sum;
   logic [NW-1:0] missing;

   sample_row_type stim_q[$];
   score_type      score_q[$];
   int             in_idx;
   int             errors;
   int             scored;
   int             idle_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] mag(logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic [VW-1:0] interp(logic [TW-1:0] rt, logic [VW-1:0] rv,
                                            logic [TW-1:0] gt);
      logic signed [63:0] dx, dt, dy, lv, p;
      logic [127:0] prod, quo;
      logic neg;
      lv   = {{32{left_v[31]}}, left_v};
      dx   = $signed({16'b0, rt}) - $signed({16'b0, left_t});
      dt   = $signed({16'b0, gt}) - $signed({16'b0, left_t});
      dy   = $signed({{32{rv[31]}}, rv}) - lv;
      if (dx == 0 || dt == 0 || dy == 0) return left_v;
      prod = {64'b0, mag(dy)} * {64'b0, mag(dt)};
      quo  = prod / {64'b0, mag(dx)};
      if (quo > (128'd1 << 40)) quo = 128'd1 << 40;
      neg  = ((dy < 0) != (dt < 0)) != (dx < 0);
      p    = neg ? lv - $signed(quo[63:0]) : lv + $signed(quo[63:0]);
      if (p > 64'sh7FFF_FFFF) p = 64'sh7FFF_FFFF;
      if (p < -64'sh8000_0000) p = -64'sh8000_0000;
      return p[31:0];
   endfunction

   function automatic logic [SW-1:0] sat_add(logic [SW-1:0] a, logic [SW-1:0] b);
      return (b > gls_pkg::MAX63 - a) ? gls_pkg::MAX63 : a + b;
   endfunction

   task automatic score_sample(sample_row_type s);
      score_type r;
      logic signed [63:0] diff;
      logic [63:0] ae;
      logic [127:0] se;
      int first;
      if (s.corrupt) begin
         if (missing != '1) missing++;
         if (gap_fill < DEPTH) begin
            gap_t[gap_fill] = s.stamp;
            gap_v[gap_fill] = s.value;
            gap_fill++;
         end else begin
            gap_overflow = 1'b1;
         end
         return;
      end
      first = score_q.size();
      for (int k = 0; k < gap_fill; k++) begin
         r.gap_time  = gap_t[k];
         r.predicted = interp(s.stamp, s.value, gap_t[k]);
         diff = $signed({{32{r.predicted[31]}}, r.predicted})
              - $signed({{32{gap_v[k][31]}}, gap_v[k]});
         ae = mag(diff);
         se = {64'b0, ae} * {64'b0, ae};
         if (se > {64'b0, SQ_MAX}) se = {64'b0, SQ_MAX};
         abs_sum = sat_add(abs_sum, ae[SW-1:0]);
         sq_sum  = sat_add(sq_sum, se[SW-1:0]);
         r.abs_error     = ae[31:0];
         r.sq_error      = se[SW-1:0];
         r.sum_abs       = abs_sum;
         r.sum_sq        = sq_sum;
         r.corrupt_count = missing;
         r.last          = (k + 1 == gap_fill);
         r.dropped       = gap_overflow;
         score_q.push_back(r);
      end
      if (s.has_pred && score_q.size() > first && score_q[first].predicted != s.pred) begin
         $display("%0t: typed prediction mismatch: expected %h actual %h",
                  $time, s.pred, score_q[first].predicted);
         errors++;
      end
      gap_fill     = 0;
      gap_overflow = 1'b0;
      left_t       = s.stamp;
      left_v       = s.value;
   endtask

   task automatic check_word();
      score_type e, a;
      a.gap_time      = rsp_tdata[47:0];
      a.predicted     = rsp_tdata[79:48];
      a.abs_error     = rsp_tdata[111:80];
      a.sq_error      = rsp_tdata[174:112];
      a.sum_abs       = rsp_tdata[237:175];
      a.sum_sq        = rsp_tdata[300:238];
      a.corrupt_count = rsp_tdata[332:301];
      a.last          = rsp_tlast;
      a.dropped       = rsp_tuser;
      if (score_q.size() == 0) begin
         $display("%0t: unexpected result word: actual %p", $time, a);
         errors++;
         return;
      end
      e = score_q.pop_front();
      scored++;
      if (e.gap_time != a.gap_time)
         $display("%0t: gap_time expected %h actual %h", $time, e.gap_time, a.gap_time);
      if (e.predicted != a.predicted)
         $display("%0t: predicted expected %h actual %h", $time, e.predicted, a.predicted);
      if (e.abs_error != a.abs_error)
         $display("%0t: abs_error expected %h actual %h", $time, e.abs_error, a.abs_error);
      if (e.sq_error != a.sq_error)
         $display("%0t: sq_error expected %h actual %h", $time, e.sq_error, a.sq_error);
      if (e.sum_abs != a.sum_abs)
         $display("%0t: sum_abs expected %h actual %h", $time, e.sum_abs, a.sum_abs);
      if (e.sum_sq != a.sum_sq)
         $display("%0t: sum_sq expected %h actual %h", $time, e.sum_sq, a.sum_sq);
      if (e.corrupt_count != a.corrupt_count)
         $display("%0t: corrupt_count expected %h actual %h", $time,
                  e.corrupt_count, a.corrupt_count);
      if (e.last != a.last)
         $display("%0t: last expected %b actual %b", $time, e.last, a.last);
      if (e.dropped != a.dropped)
         $display("%0t: dropped expected %b actual %b", $time, e.dropped, a.dropped);
      if (e != a) errors++;
   endtask

   // monitor: predict on accepted input words, check accepted result words
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            score_sample(stim_q[in_idx]);
            in_idx++;
         end
         if (rsp_tvalid && rsp_tready) check_word();
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_MAX) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   function automatic logic [VW-1:0] rand_value();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3, 4: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [TW-1:0] rand_time();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[TW-1:0];
   endfunction

   task automatic add_row(logic [TW-1:0] ts, logic [VW-1:0] v, logic c,
                          logic hp = 1'b0, logic [VW-1:0] p = '0);
      sample_row_type s;
      s.stamp = ts; s.value = v; s.corrupt = c; s.has_pred = hp; s.pred = p;
      stim_q.push_back(s);
   endtask

   task automatic build_stimulus();
      logic [TW-1:0]     d_time [N_DIR];
      logic [VW-1:0]     d_value [N_DIR];
      logic              d_corrupt [N_DIR];
      logic              d_has_pred [N_DIR];
      logic [VW-1:0]     d_pred [N_DIR];
      logic [TW-1:0]     now;
      int n, total;
      // gap before any good sample uses the origin as left point; equal times
      // predict the left value; points outside the interval, time extremes;
      // good sample with nothing buffered
      d_time     = '{48'd5, 48'd10, 48'd10, 48'd10, 48'hFFFF_FFFF_FFFF, 48'd0, 48'd1,
                     48'd2, 48'd3, 48'd4, 48'd5, 48'h8000_0000_0000,
                     48'hFFFF_FFFF_FFFF, 48'd20, 48'd20, 48'd7};
      d_value    = '{32'h0003_0000, 32'h000A_0000, 32'h0000_0007, 32'h0000_0100,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_1234,
                     32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
      d_corrupt  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0,
                     1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
      d_has_pred = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
      d_pred     = '{32'h0, 32'h0005_0000, 32'h0, 32'h000A_0000, 32'h0, 32'h0, 32'h0,
                     32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
      for (int i = 0; i < N_DIR; i++)
         add_row(d_time[i], d_value[i], d_corrupt[i], d_has_pred[i], d_pred[i]);
      // random gaps: mostly short and in time order, a few full and overflowing
      now   = 48'd100;
      total = stim_q.size();
      for (int g = 0; total < N_ITEMS; g++) begin
         if (g == 6) n = DEPTH;
         else if (g == 12) n = DEPTH + 5;
         else if ($urandom_range(0, 9) == 0) n = $urandom_range(8, 20);
         else n = $urandom_range(0, 5);
         for (int k = 0; k <= n; k++) begin
            if ($urandom_range(0, 9) == 0) now = rand_time();
            else now = now + $urandom_range(0, 40);
            add_row(now, rand_value(), k < n);
         end
         total += n + 1;
      end
   endtask

   // sender
   initial begin
      int gap;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      errors      = 0;
      scored      = 0;
      idle_cycles = 0;
      in_idx      = 0;
      left_t = '0; left_v = '0; gap_fill = 0; gap_overflow = 1'b0;
      abs_sum = '0; sq_sum = '0; missing = '0;
      build_stimulus();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < stim_q.size(); i++) begin
         gap = (i % 64 < 16) ? 0 : $urandom_range(0, 15);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= {stim_q[i].value, stim_q[i].stamp};
         req_tuser  <= stim_q[i].corrupt;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
      end
      req_tvalid <= 1'b0;
      while (in_idx != stim_q.size()) @(posedge clock);
      while (score_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0 && score_q.size() == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   // receiver, with one long hold-off to back the block up
   initial begin
      int stall;
      bit held;
      held       = 1'b0;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if (!held && scored >= 30) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_LEN) @(posedge clock);
         end else begin
            stall = ((scored / 20) % 3 == 0) ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

endmodule
`default_nettype wire

FILE: files.f
rtl/core/gls_pkg.sv
rtl/core/gls_fifo.sv
rtl/core/gls_front.sv
rtl/core/gls_back.sv
rtl/core/gap_linear_interpolation_scorer_top.sv
dv/tb_gap_linear_interpolation_scorer_top.sv
